// ===== rtl/rhtf_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the frame checker.
package rhtf_pkg;

    // Frame layout: two data bytes and one CRC byte per word, two words.
    localparam logic [2:0] POS_T_CRC   = 3'd2;
    localparam logic [2:0] POS_H_CRC   = 3'd5;
    localparam logic [2:0] FRAME_BYTES = 3'd6;

    // CRC-8 with polynomial 0x31, initial value 0xFF, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion constants.
    localparam logic [14:0] T_SCALE  = 15'd17500;
    localparam logic [13:0] H_SCALE  = 14'd10000;
    localparam logic [15:0] T_OFFSET = 16'd4500;
    localparam logic [16:0] DIV_K    = 17'd65535;

    // Queue sizes between front and back and at the result side.
    localparam int FQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    // One complete frame as handed from the front to the back.
    typedef struct packed {
        logic        status;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
    } t_frame;

    // One converted result item.
    typedef struct packed {
        logic               status;
        logic [15:0]        t_raw;
        logic [15:0]        h_raw;
        logic signed [14:0] t_centi;
        logic [13:0]        h_centi;
    } t_result;

    // Fill status of the frame queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_fq_stat;

    // Feed one byte into the running CRC, one bit per step.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/rh_temp_frame_crc_convert.sv =====
// Top level of the sensor frame checker: front, frame queue and back.
//
// Input channel: one response byte per item on i_rx_byte, with i_frame_start
// marking the first byte of a frame. An item is taken at a clock edge with
// push high and full low. Six bytes form a frame: temperature high, low and
// CRC, then humidity high, low and CRC.
// Result channel: after the sixth byte one item carries the CRC status, both
// raw words and the converted values. The oldest result is shown while empty
// is low and is taken at a clock edge with pop high.
// Throughput: one byte per cycle while full is low. The front takes every byte
// without a wait; the back runs one frame at a time through a multiply register
// and a correction step into a two-entry result queue.
// Path: the frame completed by the sixth byte is written into the frame queue,
// then into the multiply register and then into the result queue.
// Stalls: when pop stays low the result queue and then the two-entry frame
// queue fill; full rises only when the frame queue holds two frames.
// Reset: synchronous and active low; it empties both queues and restarts the
// byte position with the CRC at its initial value.
module rh_temp_frame_crc_convert import rhtf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               empty,
    input  logic               pop,
    output logic               o_status,
    output logic [15:0]        o_temperature_raw,
    output logic [15:0]        o_humidity_raw,
    output logic signed [14:0] o_temperature_centi,
    output logic [13:0]        o_humidity_centi
);

    logic     accept;
    logic     frame_vld;
    t_frame   frame_in;
    t_frame   frame_out;
    t_fq_stat fq_stat;
    logic     fq_pop;
    t_result  result;

    assign full   = fq_stat.full;
    assign accept = push && !full;

    // Byte tracking and CRC checks.
    rhtf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_frame_vld   (frame_vld),
        .o_frame       (frame_in)
    );

    // Frame queue between front and back.
    rhtf_frame_q u_frame_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (frame_vld),
        .i_frame (frame_in),
        .i_rd    (fq_pop),
        .o_frame (frame_out),
        .o_stat  (fq_stat)
    );

    // Conversion and result queue.
    rhtf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fq_stat (fq_stat),
        .i_frame   (frame_out),
        .o_fq_pop  (fq_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_status            = result.status;
    assign o_temperature_raw   = result.t_raw;
    assign o_humidity_raw      = result.h_raw;
    assign o_temperature_centi = result.t_centi;
    assign o_humidity_centi    = result.h_centi;

`ifndef SYNTH
    // Reset leaves no result waiting and room for input.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A shown temperature stays within the sensor range.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_temperature_centi >= -15'sd4500 && o_temperature_centi <= 15'sd13000))
        else $error("temperature out of range");

    // A shown humidity never exceeds one hundred percent.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_humidity_centi <= 14'd10000))
        else $error("humidity out of range");

    // Input can only be refused while results are backed up on the output side.
    a_full_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("input refused with no result waiting");
`endif

endmodule

// ===== rtl/rhtf_front.sv =====
// Front part: tracks the byte position, checks both CRCs and assembles frames.
module rhtf_front import rhtf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output logic       o_frame_vld,
    output t_frame     o_frame
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_t_word, n_t_word;
    logic        r_t_ok, n_t_ok;
    logic [15:0] r_h_word, n_h_word;

    logic        restart;
    logic [2:0]  cur_pos;
    logic [7:0]  cur_crc;

    // A frame start flag or an out-of-range position restarts the frame.
    assign restart = i_frame_start || (r_pos >= FRAME_BYTES);
    assign cur_pos = restart ? 3'd0 : r_pos;
    assign cur_crc = restart ? CRC_INIT : r_crc;

    // Byte handling per frame position.
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_t_word    = r_t_word;
        n_t_ok      = r_t_ok;
        n_h_word    = r_h_word;
        o_frame_vld = 1'b0;
        if (i_accept) begin
            n_pos = cur_pos + 3'd1;
            priority if (cur_pos < POS_T_CRC) begin
                n_crc    = crc8_feed(cur_crc, i_rx_byte);
                n_t_word = {r_t_word[7:0], i_rx_byte};
            end else if (cur_pos == POS_T_CRC) begin
                n_t_ok = (cur_crc == i_rx_byte);
                n_crc  = CRC_INIT;
            end else if (cur_pos < POS_H_CRC) begin
                n_crc    = crc8_feed(cur_crc, i_rx_byte);
                n_h_word = {r_h_word[7:0], i_rx_byte};
            end else begin
                o_frame_vld = 1'b1;
                n_crc       = CRC_INIT;
                n_pos       = 3'd0;
            end
        end
    end

    // The finished frame is formed from the last byte and the stored words.
    assign o_frame.status = !(r_t_ok && (cur_crc == i_rx_byte));
    assign o_frame.t_raw  = r_t_word;
    assign o_frame.h_raw  = r_h_word;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 3'd0;
            r_crc    <= CRC_INIT;
            r_t_word <= 16'd0;
            r_t_ok   <= 1'b0;
            r_h_word <= 16'd0;
        end else begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_t_word <= n_t_word;
            r_t_ok   <= n_t_ok;
            r_h_word <= n_h_word;
        end
    end

endmodule

// ===== rtl/rhtf_frame_q.sv =====
// Short queue of complete frames between the front and the back.
module rhtf_frame_q import rhtf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr,
    input  t_frame   i_frame,
    input  logic     i_rd,
    output t_frame   o_frame,
    output t_fq_stat o_stat
);

    localparam int AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int CW = $clog2(FQ_DEPTH + 1);

    t_frame        r_mem [FQ_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_stat.empty = (r_cnt == CW'(0));
    assign o_stat.full  = (r_cnt == CW'(FQ_DEPTH));
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;
    assign o_frame      = r_mem[r_rp];

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == AW'(FQ_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == AW'(FQ_DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_wr) - CW'(do_rd);
        end
    end

endmodule

// ===== rtl/rhtf_back.sv =====
// Back part: scales both raw words, subtracts the temperature offset and queues the finished results.
module rhtf_back import rhtf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fq_stat i_fq_stat,
    input  t_frame   i_frame,
    output logic     o_fq_pop,
    input  logic     i_pop,
    output logic     o_empty,
    output t_result  o_result
);

    localparam int AW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int CW = $clog2(OQ_DEPTH + 1);

    // Multiply stage.
    logic        r_s1_vld;
    logic        r_s1_status;
    logic [15:0] r_s1_t_raw;
    logic [15:0] r_s1_h_raw;
    logic [30:0] r_s1_t_prod;
    logic [29:0] r_s1_h_prod;

    // Result queue.
    t_result       r_oq [OQ_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    logic    oq_room;
    logic    s1_ready;
    logic    oq_wr;
    logic    oq_rd;
    t_result res;

    logic [14:0] t_q0;
    logic [16:0] t_rem;
    logic [14:0] t_q;
    logic [15:0] t_diff;
    logic [13:0] h_q0;
    logic [16:0] h_rem;
    logic [13:0] h_q;

    // Flow control between the frame queue, the multiply stage and the result queue.
    assign oq_room  = (r_cnt != CW'(OQ_DEPTH));
    assign s1_ready = !r_s1_vld || oq_room;
    assign o_fq_pop = !i_fq_stat.empty && s1_ready;
    assign oq_wr    = r_s1_vld && oq_room;
    assign oq_rd    = i_pop && !o_empty;
    assign o_empty  = (r_cnt == CW'(0));
    assign o_result = r_oq[r_rp];

    // Multiply stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ready) begin
            r_s1_vld <= o_fq_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fq_pop) begin
            r_s1_status <= i_frame.status;
            r_s1_t_raw  <= i_frame.t_raw;
            r_s1_h_raw  <= i_frame.h_raw;
            r_s1_t_prod <= 31'(i_frame.t_raw) * 31'(T_SCALE);
            r_s1_h_prod <= 30'(i_frame.h_raw) * 30'(H_SCALE);
        end
    end

    // Division by 65535: p = q0*65535 + (q0 + low half), and that remainder
    // stays below twice the divisor, so one compare corrects the quotient.
    always_comb begin
        t_q0   = r_s1_t_prod[30:16];
        t_rem  = {2'b00, t_q0} + {1'b0, r_s1_t_prod[15:0]};
        t_q    = t_q0 + 15'(t_rem >= DIV_K);
        t_diff = {1'b0, t_q} - T_OFFSET;

        h_q0  = r_s1_h_prod[29:16];
        h_rem = {3'b000, h_q0} + {1'b0, r_s1_h_prod[15:0]};
        h_q   = h_q0 + 14'(h_rem >= DIV_K);

        res.status  = r_s1_status;
        res.t_raw   = r_s1_t_raw;
        res.h_raw   = r_s1_h_raw;
        res.t_centi = t_diff[14:0];
        res.h_centi = h_q;
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (oq_wr) begin
            r_oq[r_wp] <= res;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (oq_wr) begin
                r_wp <= (r_wp == AW'(OQ_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (oq_rd) begin
                r_rp <= (r_rp == AW'(OQ_DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(oq_wr) - CW'(oq_rd);
        end
    end

endmodule
